// ===== hw/rtl/cdsc_pkg.sv =====
package cdsc_pkg;

	localparam int SEQUENCE_SPACE = 1024;
	localparam int SEQ_W = 10;
	localparam int SIZE_W = 10;
	localparam int COUNT_W = 8;
	localparam logic [SEQ_W:0] SEQ_WRAP = SEQUENCE_SPACE[SEQ_W:0];
	localparam logic [1:0] VITAL_FLAG_MASK = 2'd1;

	typedef enum logic [1:0] {
		PH_HDR0    = 2'd0,
		PH_HDR1    = 2'd1,
		PH_SEQ     = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_HEADER  = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_RESEND  = 2'd2
	} event_kind_t;

	typedef struct packed {
		event_kind_t       event_kind;
		logic [1:0]        chunk_flags;
		logic [SIZE_W-1:0] chunk_size;
		logic [SEQ_W-1:0]  chunk_sequence;
		logic [SEQ_W-1:0]  expected_sequence;
		logic [7:0]        payload_byte;
		logic              last_in_chunk;
	} result_t;

endpackage

// ===== hw/rtl/chunk_deframer_with_sequence_check.sv =====
// Chunk deframer with sequence check.
// Input stream (s_*): one byte of a packet's chunk area per item. s_tuser
// marks the first byte of a packet; the chunk count and connection flag in
// s_tdata are sampled on that byte only.
// Output stream (m_*): header accepted, payload byte or resend request, with
// the kind in m_tuser and the last payload byte of a chunk flagged on m_tlast.
// Header bytes but the last, rejected chunks' payload and surplus bytes yield no item.
// Throughput: one input item per cycle; all parsing and the sequence compare
// are done in the cycle the byte is accepted and the result is registered.
// Each result is registered in the output stage before it appears on m_*.
// When the receiver stalls, one further result is held in a skid stage and
// s_tready drops only while that stage is occupied.
// Reset clears the parse state, the chunk count and the ack to zero, so bytes
// arriving before the first packet start are ignored.
module chunk_deframer_with_sequence_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], chunk_count[15:8], connected[16], zero
	input  logic        s_tuser,   // packet_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // chunk_flags[1:0], chunk_size[11:2],
	                               // chunk_sequence[21:12], expected_sequence[31:22],
	                               // payload_byte[39:32]
	output logic [1:0]  m_tuser,   // event_kind
	output logic        m_tlast    // last_in_chunk
);
	import cdsc_pkg::*;

	logic    take, res_valid;
	result_t res, out_res;

	assign take = s_tvalid && s_tready;

	cdsc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (s_tdata[7:0]),
		.packet_start (s_tuser),
		.chunk_count  (s_tdata[15:8]),
		.connected    (s_tdata[16]),
		.res_valid    (res_valid),
		.res          (res)
	);

	cdsc_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.out_ready (m_tready)
	);

	assign m_tdata = {out_res.payload_byte, out_res.expected_sequence,
	                  out_res.chunk_sequence, out_res.chunk_size, out_res.chunk_flags};
	assign m_tuser = out_res.event_kind;
	assign m_tlast = out_res.last_in_chunk;

endmodule

// ===== hw/rtl/cdsc_parser.sv =====
module cdsc_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             data_byte,
	input  logic                   packet_start,
	input  logic [7:0]             chunk_count,
	input  logic                   connected,
	output logic                   res_valid,
	output cdsc_pkg::result_t      res
);
	import cdsc_pkg::*;

	phase_t              phase_q, phase_eff, phase_n;
	logic [7:0]          fhb_q, fhb_n, shb_q, shb_n;
	logic [SIZE_W-1:0]   rem_q, rem_eff, rem_n, rem_dec;
	logic [COUNT_W-1:0]  cnt_q, cnt_eff, cnt_n;
	logic [SEQ_W-1:0]    ack_q, ack_n, expect_seq, hdr_seq;
	logic [SEQ_W:0]      ack_inc;
	logic                disc_q, disc_eff, disc_n;
	logic                conn_q, conn_eff;
	logic [7:0]          hdr_shb;
	logic [1:0]          hdr_flags;
	logic [SIZE_W-1:0]   hdr_size;
	logic                vital_now;

	// a new packet abandons whatever was in progress
	assign phase_eff = packet_start ? PH_HDR0 : phase_q;
	assign cnt_eff   = packet_start ? chunk_count : cnt_q;
	assign conn_eff  = packet_start ? connected : conn_q;
	assign rem_eff   = packet_start ? '0 : rem_q;
	assign disc_eff  = packet_start ? 1'b0 : disc_q;

	assign ack_inc    = {1'b0, ack_q} + {{SEQ_W{1'b0}}, 1'b1};
	assign expect_seq = (ack_inc == SEQ_WRAP) ? '0 : ack_inc[SEQ_W-1:0];

	assign hdr_shb   = (phase_eff == PH_HDR1) ? data_byte : shb_q;
	assign hdr_flags = fhb_q[7:6];
	assign hdr_size  = {fhb_q[5:0], hdr_shb[3:0]};
	assign hdr_seq   = {hdr_shb[7:6], hdr_shb[5:4] | data_byte[7:6], data_byte[5:0]};
	assign vital_now = |(fhb_q[7:6] & VITAL_FLAG_MASK);
	assign rem_dec   = rem_eff - {{(SIZE_W-1){1'b0}}, 1'b1};

	always_comb begin
		phase_n   = phase_eff;
		cnt_n     = cnt_eff;
		rem_n     = rem_eff;
		disc_n    = disc_eff;
		ack_n     = ack_q;
		fhb_n     = fhb_q;
		shb_n     = shb_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_eff)
			PH_HDR0: begin
				if (cnt_eff != '0) begin
					cnt_n   = cnt_eff - {{(COUNT_W-1){1'b0}}, 1'b1};
					fhb_n   = data_byte;
					phase_n = PH_HDR1;
				end
			end
			PH_HDR1, PH_SEQ: begin
				shb_n = hdr_shb;
				if (phase_eff == PH_HDR1 && vital_now) begin
					phase_n = PH_SEQ;
				end else begin
					res_valid       = 1'b1;
					res.event_kind  = EV_HEADER;
					res.chunk_flags = hdr_flags;
					res.chunk_size  = hdr_size;
					if (phase_eff == PH_SEQ) begin
						res.chunk_sequence = hdr_seq;
						if (conn_eff) begin
							if (hdr_seq == expect_seq) begin
								ack_n = expect_seq;
							end else begin
								res.event_kind        = EV_RESEND;
								res.expected_sequence = expect_seq;
							end
						end
					end
					disc_n  = (res.event_kind == EV_RESEND);
					rem_n   = hdr_size;
					phase_n = (hdr_size != '0) ? PH_PAYLOAD : PH_HDR0;
				end
			end
			PH_PAYLOAD: begin
				if (rem_eff == '0) begin
					phase_n = PH_HDR0;
				end else begin
					rem_n = rem_dec;
					if (rem_dec == '0)
						phase_n = PH_HDR0;
					if (!disc_eff) begin
						res_valid         = 1'b1;
						res.event_kind    = EV_PAYLOAD;
						res.payload_byte  = data_byte;
						res.last_in_chunk = (rem_dec == '0);
					end
				end
			end
			default: begin
				phase_n = PH_HDR0;
			end
		endcase
		if (!take)
			res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			cnt_q   <= '0;
			rem_q   <= '0;
			disc_q  <= 1'b0;
			conn_q  <= 1'b0;
			ack_q   <= '0;
			fhb_q   <= '0;
			shb_q   <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			rem_q   <= rem_n;
			disc_q  <= disc_n;
			conn_q  <= conn_eff;
			ack_q   <= ack_n;
			fhb_q   <= fhb_n;
			shb_q   <= shb_n;
		end
	end

endmodule

// ===== hw/rtl/cdsc_out_skid.sv =====
module cdsc_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  cdsc_pkg::result_t in_data,
	output logic              in_ready,
	output logic              out_valid,
	output cdsc_pkg::result_t out_data,
	input  logic              out_ready
);
	import cdsc_pkg::*;

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// drain the skid stage once the receiver takes the waiting item
			if (out_ready) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!main_valid_q || out_ready) begin
			main_valid_q <= in_valid;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready)
				main_q <= skid_q;
		end else if (!main_valid_q || out_ready) begin
			main_q <= in_data;
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cdsc_pkg::*;

	// Tracks the deframer's parse state and queues the events it must produce
	class chunk_event_tracker;
		phase_t              phase = PH_HDR0;
		logic [7:0]          hdr0 = '0;
		logic [7:0]          hdr1 = '0;
		logic [COUNT_W-1:0]  chunks_left = '0;
		logic [SIZE_W-1:0]   payload_left = '0;
		logic [SEQ_W-1:0]    acked = '0;
		logic                dropping = 1'b0;
		logic                on_connection = 1'b0;
		result_t             pending_events[$];
		int                  errors = 0;

		function void close_header(logic [7:0] seq_low, logic vital);
			result_t          ev;
			logic [SEQ_W-1:0] next_seq;
			ev = '0;
			ev.event_kind = EV_HEADER;
			ev.chunk_flags = hdr0[7:6];
			ev.chunk_size = {hdr0[5:0], hdr1[3:0]};
			if (vital) begin
				// upper nibble of the second byte overlaps the low sequence byte
				ev.chunk_sequence = {hdr1[7:4], 6'd0} | {2'd0, seq_low};
				if (on_connection) begin
					next_seq = SEQ_W'((int'(acked) + 1) % SEQUENCE_SPACE);
					if (ev.chunk_sequence == next_seq) begin
						acked = next_seq;
					end else begin
						ev.event_kind = EV_RESEND;
						ev.expected_sequence = next_seq;
					end
				end
			end
			dropping = (ev.event_kind == EV_RESEND);
			payload_left = ev.chunk_size;
			phase = (ev.chunk_size != '0) ? PH_PAYLOAD : PH_HDR0;
			pending_events.push_back(ev);
		endfunction

		// Returns 0 when the byte is ignored
		function bit note_byte(logic [7:0] b, logic first, logic [7:0] cnt, logic conn);
			result_t ev;
			if (first) begin
				chunks_left = cnt;
				on_connection = conn;
				phase = PH_HDR0;
				payload_left = '0;
				dropping = 1'b0;
			end
			case (phase)
				PH_HDR0: begin
					if (chunks_left == '0)
						return 1'b0;
					chunks_left = chunks_left - 1'b1;
					hdr0 = b;
					phase = PH_HDR1;
				end
				PH_HDR1: begin
					hdr1 = b;
					if ((hdr0[7:6] & VITAL_FLAG_MASK) != 2'd0)
						phase = PH_SEQ;
					else
						close_header(8'd0, 1'b0);
				end
				PH_SEQ: begin
					close_header(b, 1'b1);
				end
				default: begin
					if (payload_left == '0) begin
						phase = PH_HDR0;
					end else begin
						payload_left = payload_left - 1'b1;
						if (payload_left == '0)
							phase = PH_HDR0;
						if (!dropping) begin
							ev = '0;
							ev.event_kind = EV_PAYLOAD;
							ev.payload_byte = b;
							ev.last_in_chunk = (payload_left == '0);
							pending_events.push_back(ev);
						end
					end
				end
			endcase
			return 1'b1;
		endfunction

		function void check_field(string field, int want, int seen);
			if (want != seen) begin
				$display("%0t: %s expected %0d got %0d", $time, field, want, seen);
				errors++;
			end
		endfunction

		function void check_event(logic [1:0] kind, logic [39:0] d, logic last);
			result_t want;
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event kind %0d data %h last %b",
					$time, kind, d, last);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			check_field("event_kind", int'(want.event_kind), int'(kind));
			check_field("chunk_flags", int'(want.chunk_flags), int'(d[1:0]));
			check_field("chunk_size", int'(want.chunk_size), int'(d[11:2]));
			check_field("chunk_sequence", int'(want.chunk_sequence), int'(d[21:12]));
			check_field("expected_sequence", int'(want.expected_sequence),
				int'(d[31:22]));
			check_field("payload_byte", int'(want.payload_byte), int'(d[39:32]));
			check_field("last_in_chunk", int'(want.last_in_chunk), int'(last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	chunk_event_tracker tracker = new;
	logic [7:0]         frame_bytes[$];
	bit                 tx_calm;
	bit                 hold_pending;
	int                 items_used;

	chunk_deframer_with_sequence_check i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_byte(input logic [7:0] b, input logic first,
			input logic [7:0] cnt, input logic conn);
		int   gap;
		logic ok;
		gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, conn, cnt, b};
		s_tuser <= first;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		if (tracker.note_byte(b, first, cnt, conn))
			items_used++;
	endtask

	// Append a chunk header and its payload to the frame under construction
	function automatic void add_chunk(logic [1:0] flags, logic [9:0] size, logic [9:0] seq,
			int payload_len);
		logic       vital;
		logic [3:0] upper;
		vital = (flags & VITAL_FLAG_MASK) != 2'd0;
		upper = 4'($urandom);
		if (vital)
			upper = {seq[9:8], seq[7:6] & 2'($urandom)};
		frame_bytes.push_back({flags, size[9:4]});
		frame_bytes.push_back({upper, size[3:0]});
		if (vital)
			frame_bytes.push_back(seq[7:0]);
		repeat (payload_len) frame_bytes.push_back(8'($urandom));
	endfunction

	// Count and connection travel only with the first byte; noise elsewhere
	task automatic send_frame(input logic [7:0] count, input logic conn);
		foreach (frame_bytes[i])
			push_byte(frame_bytes[i], i == 0, (i == 0) ? count : 8'($urandom),
				(i == 0) ? conn : 1'($urandom));
		frame_bytes.delete();
	endtask

	task automatic random_frame();
		logic [7:0] count;
		logic       conn;
		logic [9:0] ack;
		logic [1:0] flags;
		logic [9:0] size;
		logic [9:0] seq;
		int         n;
		int         style;
		int         keep;
		count = ($urandom_range(0, 19) == 0) ? 8'd0 :
			($urandom_range(0, 19) == 0) ? 8'($urandom_range(7, 255)) :
			8'($urandom_range(1, 5));
		conn = ($urandom_range(0, 4) != 0);
		ack = tracker.acked;
		n = (count > 6) ? 6 : count;
		for (int i = 0; i < n; i++) begin
			flags = 2'($urandom);
			size = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(7, 60)) :
				10'($urandom_range(0, 6));
			seq = 10'($urandom);
			if ((flags & VITAL_FLAG_MASK) != 2'd0 && conn) begin
				if ($urandom_range(0, 4) != 0) begin
					ack = SEQ_W'((int'(ack) + 1) % SEQUENCE_SPACE);
					seq = ack;
				end else begin
					// never ack plus one
					seq = ack + 10'($urandom_range(2, 1023));
				end
			end
			add_chunk(flags, size, seq, int'(size));
		end
		if (n == count)
			repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom));
		style = $urandom_range(0, 9);
		if (style == 0 && frame_bytes.size() > 1) begin
			// cut short: the next packet start abandons the chunk
			keep = $urandom_range(1, frame_bytes.size() - 1);
			while (frame_bytes.size() > keep)
				frame_bytes.delete(frame_bytes.size() - 1);
		end else if (style == 1) begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
		end
		if (frame_bytes.size() == 0)
			frame_bytes.push_back(8'($urandom));
		tx_calm = ($urandom_range(0, 3) == 0);
		send_frame(count, conn);
	endtask

	initial begin : byte_source
		int frames;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_calm = 1'b0;
		// no packet seen yet: ignored
		push_byte(8'($urandom), 1'b0, 8'($urandom), 1'b1);
		push_byte(8'($urandom), 1'b0, 8'($urandom), 1'b1);
		// full count, zero size plain chunk, in-order vital, out-of-order vital
		add_chunk(2'b10, 10'd0, 10'd0, 0);
		add_chunk(2'b11, 10'd1, 10'd1, 1);
		add_chunk(2'b01, 10'd2, 10'd1023, 2);
		send_frame(8'd255, 1'b1);
		// vital chunk off a connection, largest size, abandoned by the next start
		add_chunk(2'b01, 10'd1023, 10'd1023, 3);
		send_frame(8'd1, 1'b0);
		// zero count: every byte ignored
		frame_bytes.push_back(8'hff);
		frame_bytes.push_back(8'h00);
		send_frame(8'd0, 1'b1);
		// surplus bytes after the count is used up
		add_chunk(2'b00, 10'd1, 10'd0, 1);
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'($urandom));
		send_frame(8'd1, 1'b1);

		items_used = 0;
		frames = 0;
		while (items_used < 700) begin
			if (frames == 10) begin
				// receiver holds off while a long chunk streams in back to back
				hold_pending = 1'b1;
				add_chunk(2'b00, 10'd60, 10'd0, 60);
				tx_calm = 1'b1;
				send_frame(8'd1, 1'b0);
			end else begin
				random_frame();
			end
			frames++;
		end
		s_tvalid <= 1'b0;

		while (tracker.pending_events.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
			$display("chunk_deframer_with_sequence_check verification clean");
		end else begin
			$display("chunk_deframer_with_sequence_check verification failed");
		end
		$finish;
	end

	initial begin : event_sink
		int          gap;
		int          calm_left;
		logic        calm;
		logic        got;
		logic        last;
		logic [1:0]  kind;
		logic [39:0] data;
		calm_left = 0;
		calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(10, 40);
			end
			calm_left--;
			gap = calm ? 0 : $urandom_range(0, 10);
			if (hold_pending) begin
				hold_pending = 1'b0;
				gap = 200;
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				got = m_tvalid;
				kind = m_tuser;
				data = m_tdata;
				last = m_tlast;
				@(posedge clk);
			end while (!got);
			tracker.check_event(kind, data, last);
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("chunk_deframer_with_sequence_check verification failed");
		$finish;
	end

endmodule
